FILE: sv/bitmap_page_frame_allocator_unit_macros.svh
// assertion helpers for the frame allocator
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, ignored during reset
`define BPFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored during reset
`define BPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bpfa_pkg.sv
package bpfa_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int MAP_WORDS   = MAX_FRAMES / 64;
    localparam int FRAME_SHIFT = 12;

    // operation codes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ALLOC1 = 3'd1;
    localparam logic [2:0] OP_ALLOCN = 3'd2;
    localparam logic [2:0] OP_FREE   = 3'd3;
    localparam logic [2:0] OP_RES    = 3'd4;
    localparam logic [2:0] OP_UNRES  = 3'd5;

    // configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_TOTAL = 1'b1;

endpackage

FILE: sv/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator: one used bit per 4 KiB frame, up to 4096 frames, held in a
// 64 x 64 synchronous bitmap RAM with one read and one write port, plus a free-frame counter.
// Requests come in on the s_axis side, one result per request leaves on the m_axis side; one
// request is worked at a time and the next is taken while a result still waits.
// Init writes zeros over all 64 map words, marking frame zero used when the limit is nonzero.
// An allocation reads the map word by word from frame zero up to the found run, then marks
// its frames with a read and a write-back each; it ends right after setup when too few
// frames are free. Free and reserve/unreserve read and write back each frame in the managed
// range. Requests other than init before the first init, and unused operation codes, return
// at once with success low.
`include "bitmap_page_frame_allocator_unit_macros.svh"

module bitmap_page_frame_allocator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration writes
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [51:0]   i_cfg_data,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // address[63:0], frame_count[76:64], byte_size[128:77]
    input  logic [2:0]    s_axis_tuser,   // operation[2:0]
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [79:0]   m_axis_tdata    // frame_address[63:0], success[64], free_count[77:65]
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SBIT  = 4'd4;
    localparam logic [3:0] ST_WRD   = 4'd5;
    localparam logic [3:0] ST_WWR   = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    localparam logic [12:0] MAXF = 13'(bpfa_pkg::MAX_FRAMES);

    logic [3:0]  r_state;
    logic [2:0]  r_op;
    logic [63:0] r_addr;
    logic [12:0] r_cnt;
    logic [51:0] r_bytes;
    logic [51:0] r_base;
    logic [12:0] r_total;
    logic        r_ready;
    logic [12:0] r_free;
    logic [12:0] r_idx;
    logic [12:0] r_end;
    logic [12:0] r_run;
    logic [11:0] r_start;
    logic [63:0] r_a;
    logic [12:0] r_i;
    logic [63:0] r_res_addr;
    logic        r_ok;
    logic        r_ovalid;
    logic [63:0] r_oaddr;
    logic        r_ook;
    logic [12:0] r_ofree;

    // bitmap memory
    logic [63:0] r_mem [bpfa_pkg::MAP_WORDS];
    logic [63:0] r_rdata;

    logic [12:0] w_total;
    logic [63:0] w_base64;
    logic [63:0] w_fdiff;
    logic        w_fhit;
    logic [63:0] w_sdiff;
    logic [51:0] w_first;
    logic        w_first_in;
    logic [52:0] w_nsum;
    logic [40:0] w_n;
    logic [12:0] w_rem;
    logic [12:0] w_end;
    logic [12:0] w_want;
    logic [12:0] w_run_n;
    logic [11:0] w_beg;
    logic        w_bit;
    logic        w_set;
    logic        w_flip;
    logic [63:0] w_onehot;
    logic        w_we;
    logic [5:0]  w_waddr;
    logic [63:0] w_wdata;
    logic [5:0]  w_raddr;
    logic        w_accept;

    // live frame limit and base
    assign w_total  = (r_total > MAXF) ? MAXF : r_total;
    assign w_base64 = {12'd0, r_base};

    // free walk: frame index of the current address
    assign w_fdiff = r_a - w_base64;
    assign w_fhit  = (r_a >= w_base64) && (w_fdiff[63:12] < {39'd0, w_total});

    // reserve range bounds
    assign w_sdiff    = r_addr - w_base64;
    assign w_first    = (r_addr > w_base64) ? w_sdiff[63:12] : 52'd0;
    assign w_first_in = w_first < {39'd0, w_total};
    assign w_nsum     = {1'b0, r_bytes} + 53'd4095;
    assign w_n        = w_nsum[52:12];
    assign w_rem      = w_total - w_first[12:0];
    assign w_end      = (w_n < {28'd0, w_rem}) ? (w_first[12:0] + w_n[12:0]) : w_total;

    // run search
    assign w_want  = (r_op == bpfa_pkg::OP_ALLOC1) ? 13'd1 : r_cnt;
    assign w_run_n = r_run + 13'd1;
    assign w_beg   = (r_run == 13'd0) ? r_idx[11:0] : r_start;

    // bit modify
    assign w_bit    = r_rdata[r_idx[5:0]];
    assign w_set    = (r_op != bpfa_pkg::OP_FREE) && (r_op != bpfa_pkg::OP_UNRES);
    assign w_flip   = w_set ? !w_bit : w_bit;
    assign w_onehot = 64'd1 << r_idx[5:0];

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[11:6];
        w_wdata = w_set ? (r_rdata | w_onehot) : (r_rdata & ~w_onehot);
        w_raddr = r_idx[11:6];
        if (r_state == ST_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_idx[5:0];
            w_wdata = ((r_idx[5:0] == 6'd0) && (w_total != 13'd0)) ? 64'd1 : 64'd0;
        end else if (r_state == ST_WWR) begin
            w_we = w_flip;
        end
        if ((r_state == ST_WRD) && (r_op == bpfa_pkg::OP_FREE)) begin
            w_raddr = w_fdiff[23:18];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 52'd0;
            r_total <= 13'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bpfa_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                bpfa_pkg::CFG_TOTAL: r_total <= i_cfg_data[12:0];
                default:             r_base  <= r_base;
            endcase
        end
    end

    // request payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= s_axis_tuser;
            r_addr  <= s_axis_tdata[63:0];
            r_cnt   <= s_axis_tdata[76:64];
            r_bytes <= s_axis_tdata[128:77];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ready  <= 1'b0;
            r_free   <= 13'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_ok       <= 1'b0;
                    r_res_addr <= 64'd0;
                    r_idx      <= 13'd0;
                    if (w_accept) begin
                        if (s_axis_tuser == bpfa_pkg::OP_INIT) begin
                            r_state <= ST_CLR;
                        end else if (!r_ready || (s_axis_tuser > bpfa_pkg::OP_UNRES)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_CLR: begin
                    if (r_idx[5:0] == 6'd63) begin
                        r_free  <= w_total - ((w_total != 13'd0) ? 13'd1 : 13'd0);
                        r_ready <= 1'b1;
                        r_ok    <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 13'd1;
                    end
                end
                ST_SETUP: begin
                    r_run <= 13'd0;
                    r_a   <= r_addr;
                    r_i   <= 13'd0;
                    case (r_op)
                        bpfa_pkg::OP_ALLOC1: begin
                            r_state <= (r_free != 13'd0) ? ST_SRD : ST_DONE;
                        end
                        bpfa_pkg::OP_ALLOCN: begin
                            r_state <= ((r_cnt != 13'd0) && (r_free >= r_cnt)) ?
                                       ST_SRD : ST_DONE;
                        end
                        bpfa_pkg::OP_FREE: begin
                            r_ok    <= 1'b1;
                            r_state <= ST_WRD;
                        end
                        default: begin
                            r_ok    <= 1'b1;
                            r_idx   <= w_first_in ? w_first[12:0] : 13'd0;
                            r_end   <= w_first_in ? w_end : 13'd0;
                            r_state <= ST_WRD;
                        end
                    endcase
                end
                ST_SRD: begin
                    r_state <= ST_SBIT;
                end
                ST_SBIT: begin
                    if (r_idx >= w_total) begin
                        r_state <= ST_DONE;
                    end else if (!w_bit && (w_run_n >= w_want)) begin
                        r_idx      <= {1'b0, w_beg};
                        r_end      <= {1'b0, w_beg} + w_want;
                        r_res_addr <= w_base64 + {40'd0, w_beg, 12'd0};
                        r_ok       <= 1'b1;
                        r_state    <= ST_WRD;
                    end else begin
                        r_run   <= w_bit ? 13'd0 : w_run_n;
                        r_start <= w_beg;
                        r_idx   <= r_idx + 13'd1;
                        if (r_idx[5:0] == 6'd63) begin
                            r_state <= ST_SRD;
                        end
                    end
                end
                ST_WRD: begin
                    if (r_op == bpfa_pkg::OP_FREE) begin
                        if (r_i == r_cnt) begin
                            r_state <= ST_DONE;
                        end else if (w_fhit) begin
                            r_idx   <= {1'b0, w_fdiff[23:12]};
                            r_state <= ST_WWR;
                        end else begin
                            r_a <= r_a + 64'd4096;
                            r_i <= r_i + 13'd1;
                        end
                    end else begin
                        r_state <= (r_idx == r_end) ? ST_DONE : ST_WWR;
                    end
                end
                ST_WWR: begin
                    if (w_flip) begin
                        if (w_set) begin
                            r_free <= (r_free != 13'd0) ? r_free - 13'd1 : r_free;
                        end else begin
                            r_free <= (r_free < MAXF) ? r_free + 13'd1 : r_free;
                        end
                    end
                    r_idx   <= r_idx + 13'd1;
                    r_a     <= r_a + 64'd4096;
                    r_i     <= r_i + 13'd1;
                    r_state <= ST_WRD;
                end
                ST_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!r_ovalid || m_axis_tready)) begin
            r_oaddr  <= r_res_addr;
            r_ook    <= r_ok;
            r_ofree  <= r_free;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'd0, r_ofree, r_ook, r_oaddr};

    // checks
    `BPFA_ASSERT_NOW(a_free_bound, 1'b1, r_free <= MAXF, "free count above capacity")
    `BPFA_ASSERT_NEXT(a_accept_busy, w_accept, r_state != ST_IDLE, "request accepted but idle")
    `BPFA_ASSERT_NEXT(a_ready_hold, r_ready, r_ready, "initialized flag dropped")

endmodule

FILE: dv/bitmap_page_frame_allocator_unit_test.sv
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_unit_test;

    localparam int unsigned RUN_LIMIT = 8000000;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] addr;
        logic [12:0] cnt;
        logic [51:0] bytes;
    } t_frame_req;

    typedef struct {
        logic [63:0] frame_addr;
        logic        ok;
        logic [12:0] free_cnt;
    } t_frame_rsp;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_addr = 1'b0;
    logic [51:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata = '0;   // address[63:0], frame_count[76:64], byte_size[128:77]
    logic [2:0]    s_axis_tuser = '0;   // operation[2:0]
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [79:0]   m_axis_tdata;        // frame_address[63:0], success[64], free_count[77:65]

    bitmap_page_frame_allocator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor state and live configuration
    bit          frame_used [bpfa_pkg::MAX_FRAMES];
    int unsigned free_ctr = 0;
    bit          map_ready = 0;
    logic [63:0] base_reg = '0;
    int unsigned total_reg = 0;

    t_frame_req  pending_reqs [$];
    t_frame_rsp  expected_rsps [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_req = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    function automatic int unsigned live_total();
        return (total_reg > bpfa_pkg::MAX_FRAMES) ? bpfa_pkg::MAX_FRAMES : total_reg;
    endfunction

    function automatic bit frame_busy(input longint unsigned idx);
        if (idx >= live_total()) return 1'b1;
        return frame_used[idx];
    endfunction

    function automatic void frame_set(input longint unsigned idx, input bit v);
        if (idx < live_total()) frame_used[idx] = v;
    endfunction

    function automatic void free_dec();
        if (free_ctr > 0) free_ctr--;
    endfunction

    function automatic void free_inc();
        if (free_ctr < bpfa_pkg::MAX_FRAMES) free_ctr++;
    endfunction

    // lowest start of a run of free frames
    function automatic bit find_free_run(input int unsigned want, output int unsigned start);
        int unsigned run;
        int unsigned first;
        run = 0;
        first = 0;
        start = 0;
        for (int unsigned i = 0; i < live_total(); i++) begin
            if (!frame_busy(i)) begin
                if (run == 0) first = i;
                run++;
                if (run >= want) begin
                    start = first;
                    return 1'b1;
                end
            end else begin
                run = 0;
            end
        end
        return 1'b0;
    endfunction

    // work out the response to one accepted request
    function automatic t_frame_rsp allocator_outcome(input t_frame_req rq);
        t_frame_rsp rsp;
        int unsigned tot;
        int unsigned start;
        longint unsigned a, idx, first, n, stop, pages;
        rsp.frame_addr = '0;
        rsp.ok = 1'b0;
        tot = live_total();
        if (rq.op == bpfa_pkg::OP_INIT) begin
            pages = (((tot + 63) / 64) + 511) / 512;
            foreach (frame_used[k]) frame_used[k] = 0;
            free_ctr = tot;
            for (longint unsigned i = 0; i < pages; i++) frame_set(i, 1'b1);
            free_ctr -= 32'(pages);
            map_ready = 1;
            rsp.ok = 1'b1;
        end else if (map_ready && rq.op == bpfa_pkg::OP_ALLOC1) begin
            if (free_ctr != 0 && find_free_run(1, start)) begin
                frame_set(64'(start), 1'b1);
                free_dec();
                rsp.frame_addr = base_reg + (64'(start) << bpfa_pkg::FRAME_SHIFT);
                rsp.ok = 1'b1;
            end
        end else if (map_ready && rq.op == bpfa_pkg::OP_ALLOCN) begin
            if (rq.cnt != 0 && free_ctr >= 32'(rq.cnt) && find_free_run(32'(rq.cnt), start))
            begin
                for (int unsigned i = 0; i < 32'(rq.cnt); i++) begin
                    frame_set(64'(start + i), 1'b1);
                    free_dec();
                end
                rsp.frame_addr = base_reg + (64'(start) << bpfa_pkg::FRAME_SHIFT);
                rsp.ok = 1'b1;
            end
        end else if (map_ready && rq.op == bpfa_pkg::OP_FREE) begin
            for (longint unsigned i = 0; i < 64'(rq.cnt); i++) begin
                a = rq.addr + (i << bpfa_pkg::FRAME_SHIFT);
                if (a >= base_reg) begin
                    idx = (a - base_reg) >> bpfa_pkg::FRAME_SHIFT;
                    if (idx < 64'(tot) && frame_busy(idx)) begin
                        frame_set(idx, 1'b0);
                        free_inc();
                    end
                end
            end
            rsp.ok = 1'b1;
        end else if (map_ready && (rq.op == bpfa_pkg::OP_RES || rq.op == bpfa_pkg::OP_UNRES)) begin
            first = (rq.addr > base_reg) ? ((rq.addr - base_reg) >> bpfa_pkg::FRAME_SHIFT) : 0;
            n = (64'(rq.bytes) + 4095) >> bpfa_pkg::FRAME_SHIFT;
            stop = (first < 64'(tot) && n < 64'(tot) - first) ? first + n : 64'(tot);
            for (longint unsigned i = first; i < stop; i++) begin
                if (rq.op == bpfa_pkg::OP_RES && !frame_busy(i)) begin
                    frame_set(i, 1'b1);
                    free_dec();
                end else if (rq.op == bpfa_pkg::OP_UNRES && frame_busy(i)) begin
                    frame_set(i, 1'b0);
                    free_inc();
                end
            end
            rsp.ok = 1'b1;
        end
        rsp.free_cnt = free_ctr[12:0];
        return rsp;
    endfunction

    // request driver: bursts with random gaps
    t_frame_req  cur_req;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) expected_rsps.push_back(allocator_outcome(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {7'd0, cur_req.bytes, cur_req.cnt, cur_req.addr};
                    s_axis_tuser <= cur_req.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern and the long hold-off
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;

    always @(posedge i_clk) begin
        t_frame_rsp want;
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rsps.size() == 0) begin
                    report("unexpected result", m_axis_tdata[63:0], 64'd0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_axis_tdata[63:0] !== want.frame_addr)
                        report("frame_address", m_axis_tdata[63:0], want.frame_addr);
                    if (m_axis_tdata[64] !== want.ok)
                        report("success", 64'(m_axis_tdata[64]), 64'(want.ok));
                    if (m_axis_tdata[77:65] !== want.free_cnt)
                        report("free_count", 64'(m_axis_tdata[77:65]), 64'(want.free_cnt));
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (cycle_count % 500 == 0) stall_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_mode == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic t_frame_req req_of(input logic [2:0] op, input logic [63:0] addr,
                                          input logic [12:0] cnt, input logic [51:0] bytes);
        t_frame_req rq;
        rq.op = op;
        rq.addr = addr;
        rq.cnt = cnt;
        rq.bytes = bytes;
        return rq;
    endfunction

    // random request, mostly aimed inside the managed range
    function automatic t_frame_req random_req();
        t_frame_req rq;
        int unsigned r;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) rq.op = bpfa_pkg::OP_INIT;
        else if (sel < 28) rq.op = bpfa_pkg::OP_ALLOC1;
        else if (sel < 48) rq.op = bpfa_pkg::OP_ALLOCN;
        else if (sel < 70) rq.op = bpfa_pkg::OP_FREE;
        else if (sel < 84) rq.op = bpfa_pkg::OP_RES;
        else if (sel < 97) rq.op = bpfa_pkg::OP_UNRES;
        else rq.op = 3'($urandom_range(6, 7));
        r = $urandom_range(0, 9);
        if (r == 0) rq.addr = {$urandom, $urandom};
        else if (r == 1) rq.addr = base_reg - 64'($urandom_range(0, 20000));
        else rq.addr = base_reg
                       + (64'($urandom_range(0, live_total() + 4)) << bpfa_pkg::FRAME_SHIFT)
                       + 64'($urandom_range(0, 4095));
        r = $urandom_range(0, 199);
        if (r == 0) rq.cnt = 13'($urandom);
        else if (r < 30) rq.cnt = 13'($urandom_range(0, 70));
        else rq.cnt = 13'($urandom_range(0, 8));
        r = $urandom_range(0, 19);
        if (r == 0) rq.bytes = 52'({$urandom, $urandom});
        else rq.bytes = 52'($urandom_range(0, 40000));
        return rq;
    endfunction

    task automatic cfg_write(input logic [63:0] base, input logic [12:0] total);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= bpfa_pkg::CFG_BASE;
        i_cfg_data <= base[51:0];
        @(posedge i_clk);
        i_cfg_addr <= bpfa_pkg::CFG_TOTAL;
        i_cfg_data <= 52'(total);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_reg = {12'd0, base[51:0]};
        total_reg = 32'(total);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [63:0] base, input logic [12:0] total,
                             input int unsigned n, input bit do_init);
        cfg_write(base, total);
        if (do_init) pending_reqs.push_back(req_of(bpfa_pkg::OP_INIT, '0, '0, '0));
        for (int unsigned i = 0; i < n; i++) pending_reqs.push_back(random_req());
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ops before init, every op, extremes
        cfg_write(64'h1000_0000, 13'd64);
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOC1, '0, 13'd1, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOCN, '0, 13'd4, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_FREE, 64'h1000_0000, 13'd4, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_RES, 64'h1000_0000, '0, 52'd4096));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_UNRES, 64'h1000_0000, '0, 52'd4096));
        pending_reqs.push_back(req_of(3'd6, '1, '1, '1));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_INIT, '0, '0, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOC1, '0, '0, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOCN, '0, 13'd0, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOCN, '0, 13'd8, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOCN, '0, 13'd100, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_FREE, 64'h1000_2000, 13'd3, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_FREE, 64'h0FFF_E000, 13'd5, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_FREE, '1, 13'd3, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_RES, '0, '0, 52'd1));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_RES, 64'h1003_0000, '0, '1));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_UNRES, 64'h1000_5000, '0, 52'd20000));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_UNRES, '1, '0, '1));
        pending_reqs.push_back(req_of(3'd7, '0, '0, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_RES, '0, '0, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOCN, '0, 13'd64, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_FREE, 64'h1000_0000, '1, '0));
        pending_reqs.push_back(req_of(bpfa_pkg::OP_ALLOCN, '0, '1, '0));
        wait_drained();

        run_phase(64'h0, 13'd4096, 80, 1);
        run_phase(64'hF_FFFF_FFFF_FFFF, 13'd200, 180, 1);
        // shrink and grow without init to reach the counter bounds
        run_phase(64'h0, 13'h1FFF, 60, 0);
        run_phase(64'h0, 13'd30, 140, 0);
        run_phase(64'h0, 13'd0, 30, 0);
        run_phase({12'd0, 52'({$urandom, $urandom})}, 13'd1, 100, 1);
        hold_req = 3000;
        run_phase({12'd0, 52'({$urandom, $urandom})}, 13'd300, 400, 1);
        run_phase(64'h4_0000, 13'd129, 240, 1);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/bpfa_pkg.sv
sv/bitmap_page_frame_allocator_unit.sv
dv/bitmap_page_frame_allocator_unit_test.sv
